FILE: sv/crdc_pkg.sv
// crdc_pkg: shared types, codes and band tables for the climate relay duty controller
// used by crdc_mode, crdc_timer and climate_relay_duty_controller
`default_nettype none

package crdc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TEMP_W    = 12;
  localparam int unsigned HUM_W     = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned SECS_W    = 12;
  localparam int unsigned WAIT_W    = 6;
  localparam int unsigned HUM_ON_W  = 5;
  localparam int unsigned HEAT_ON_W = 7;

  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(60);

  localparam logic [CFG_IDX_W-1:0] REG_ON_TEMP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_HUM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_HUM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEPA_ON     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEPA_PERIOD = 3'd7;

  localparam logic signed [TEMP_W-1:0] ON_TEMP_RST   = 12'sd100;
  localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST  = 12'sd600;
  localparam logic signed [TEMP_W-1:0] HIGH_TEMP_RST = 12'sd800;
  localparam logic [HUM_W-1:0]         ON_HUM_RST    = 10'd100;
  localparam logic [HUM_W-1:0]         OFF_HUM_RST   = 10'd400;

  typedef enum logic [2:0] {
    CMD_OFF       = 3'd0,
    CMD_START     = 3'd1,
    CMD_STAY_ON   = 3'd2,
    CMD_STAY_OFF  = 3'd3,
    CMD_UNTOUCHED = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    TMODE_HEAT = 2'd1,
    TMODE_SAT  = 2'd2,
    TMODE_OVER = 2'd3
  } temp_mode_t;

  typedef enum logic [1:0] {
    HMODE_HUMID = 2'd1,
    HMODE_SAT   = 2'd2
  } hum_mode_t;

  typedef logic [2:0] band_t;

  typedef struct packed {
    temp_mode_t tmode;
    hum_mode_t  hmode;
    band_t      tband;
    band_t      hband;
  } mode_res_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              restart;
    logic [WAIT_W-1:0] wait_secs;
  } timer_res_t;

  function automatic logic [HEAT_ON_W-1:0] heat_on_len(input band_t b);
    logic [HEAT_ON_W-1:0] r;
    case (b)
      3'd1:    r = 7'd30;
      3'd2:    r = 7'd40;
      3'd3:    r = 7'd50;
      3'd4:    r = 7'd60;
      3'd5:    r = 7'd70;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SECS_W-1:0] heat_period_len(input band_t b);
    logic [SECS_W-1:0] r;
    case (b)
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5: r = 12'd500;
      default:                      r = 12'd0;
    endcase
    return r;
  endfunction

  function automatic logic [HUM_ON_W-1:0] hum_on_len(input band_t b);
    logic [HUM_ON_W-1:0] r;
    case (b)
      3'd1:    r = 5'd5;
      3'd2:    r = 5'd10;
      3'd3:    r = 5'd15;
      3'd4:    r = 5'd20;
      3'd5:    r = 5'd30;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SECS_W-1:0] hum_period_len(input band_t b);
    logic [SECS_W-1:0] r;
    case (b)
      3'd1:    r = 12'd61;
      3'd2:    r = 12'd71;
      3'd3:    r = 12'd81;
      3'd4:    r = 12'd91;
      3'd5:    r = 12'd101;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/climate_relay_duty_controller.sv
// climate relay duty controller: an accepted input is registered in the input stage, then in the result stage
// one item per cycle unless out_ready holds the result; the input register and result register are the two stages
// and the relay state and modes update as an item moves into the result register
// rst_n is synchronous active low: modes return to satisfied, timer starts to 0,
// configuration registers to their reset values, both stages empty
`default_nettype none

module climate_relay_duty_controller (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [crdc_pkg::TIME_W-1:0]          in_now_secs,
  input  wire logic signed [crdc_pkg::TEMP_W-1:0]   in_temp_tenths,
  input  wire logic [crdc_pkg::HUM_W-1:0]           in_hum_tenths,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [1:0]                                out_temp_mode,
  output logic [1:0]                                out_hum_mode,
  output logic [2:0]                                out_hepa_cmd,
  output logic [2:0]                                out_humidifier_cmd,
  output logic [2:0]                                out_fan_cmd,
  output logic [2:0]                                out_heater_cmd,
  output logic [crdc_pkg::HUM_ON_W-1:0]             out_humidifier_pulse_secs,
  output logic [crdc_pkg::HEAT_ON_W-1:0]            out_heater_pulse_secs,
  output logic [crdc_pkg::SECS_W-1:0]               out_hepa_pulse_secs,
  output logic [crdc_pkg::WAIT_W-1:0]               out_wait_secs,
  input  wire logic                                 cfg_we,
  input  wire logic [crdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [crdc_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  // configuration
  logic signed [crdc_pkg::TEMP_W-1:0] on_temp_r, off_temp_r, high_temp_r;
  logic [crdc_pkg::HUM_W-1:0]         on_hum_r, off_hum_r;
  logic                               override_r;
  logic [crdc_pkg::SECS_W-1:0]        hepa_on_r, hepa_period_r;

  // relay state
  crdc_pkg::temp_mode_t        tmode_r;
  crdc_pkg::hum_mode_t         hmode_r;
  logic [crdc_pkg::TIME_W-1:0] heater_start_r, humid_start_r, hepa_start_r;

  // input stage
  logic                               s1_valid_r;
  logic [crdc_pkg::TIME_W-1:0]        s1_now_r;
  logic signed [crdc_pkg::TEMP_W-1:0] s1_temp_r;
  logic [crdc_pkg::HUM_W-1:0]         s1_hum_r;
  logic                               s1_fire;
  logic                               in_fire;

  // result stage
  logic                          out_valid_r;
  crdc_pkg::mode_res_t           mode_res;
  crdc_pkg::timer_res_t          hepa_res, humid_res, heat_res;
  logic                          hepa_en, humid_en, heat_en;
  logic [crdc_pkg::WAIT_W-1:0]   wait_nxt;
  logic [2:0]                    hepa_cmd_nxt, humid_cmd_nxt, fan_cmd_nxt, heat_cmd_nxt;
  logic [crdc_pkg::SECS_W-1:0]   hepa_len_nxt;
  logic [1:0]                    tmode_out_r, hmode_out_r;
  logic [2:0]                    hepa_cmd_r, humid_cmd_r, fan_cmd_r, heat_cmd_r;
  logic [crdc_pkg::HUM_ON_W-1:0] humid_len_r;
  logic [crdc_pkg::HEAT_ON_W-1:0] heat_len_r;
  logic [crdc_pkg::SECS_W-1:0]   hepa_len_r;
  logic [crdc_pkg::WAIT_W-1:0]   wait_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_temp_r     <= crdc_pkg::ON_TEMP_RST;
      off_temp_r    <= crdc_pkg::OFF_TEMP_RST;
      high_temp_r   <= crdc_pkg::HIGH_TEMP_RST;
      on_hum_r      <= crdc_pkg::ON_HUM_RST;
      off_hum_r     <= crdc_pkg::OFF_HUM_RST;
      override_r    <= 1'b0;
      hepa_on_r     <= '0;
      hepa_period_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        crdc_pkg::REG_ON_TEMP:     on_temp_r     <= cfg_wdata;
        crdc_pkg::REG_OFF_TEMP:    off_temp_r    <= cfg_wdata;
        crdc_pkg::REG_HIGH_TEMP:   high_temp_r   <= cfg_wdata;
        crdc_pkg::REG_ON_HUM:      on_hum_r      <= cfg_wdata[crdc_pkg::HUM_W-1:0];
        crdc_pkg::REG_OFF_HUM:     off_hum_r     <= cfg_wdata[crdc_pkg::HUM_W-1:0];
        crdc_pkg::REG_OVERRIDE:    override_r    <= cfg_wdata[0];
        crdc_pkg::REG_HEPA_ON:     hepa_on_r     <= cfg_wdata;
        crdc_pkg::REG_HEPA_PERIOD: hepa_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r  <= in_now_secs;
      s1_temp_r <= in_temp_tenths;
      s1_hum_r  <= in_hum_tenths;
    end
  end

  crdc_mode u_mode (
    .temp      (s1_temp_r),
    .hum       (s1_hum_r),
    .on_temp   (on_temp_r),
    .off_temp  (off_temp_r),
    .high_temp (high_temp_r),
    .on_hum    (on_hum_r),
    .off_hum   (off_hum_r),
    .tmode_cur (tmode_r),
    .hmode_cur (hmode_r),
    .res       (mode_res)
  );

  assign hepa_en  = !override_r && mode_res.tmode == crdc_pkg::TMODE_OVER;
  assign humid_en = !override_r && mode_res.hmode == crdc_pkg::HMODE_HUMID;
  assign heat_en  = !override_r && mode_res.tmode == crdc_pkg::TMODE_HEAT;

  crdc_timer u_hepa_timer (
    .enable (hepa_en),
    .now    (s1_now_r),
    .start  (hepa_start_r),
    .on_len (hepa_on_r),
    .period (hepa_period_r),
    .res    (hepa_res)
  );

  crdc_timer u_humid_timer (
    .enable (humid_en),
    .now    (s1_now_r),
    .start  (humid_start_r),
    .on_len ({{(crdc_pkg::SECS_W-crdc_pkg::HUM_ON_W){1'b0}},
              crdc_pkg::hum_on_len(mode_res.hband)}),
    .period (crdc_pkg::hum_period_len(mode_res.hband)),
    .res    (humid_res)
  );

  crdc_timer u_heat_timer (
    .enable (heat_en),
    .now    (s1_now_r),
    .start  (heater_start_r),
    .on_len ({{(crdc_pkg::SECS_W-crdc_pkg::HEAT_ON_W){1'b0}},
              crdc_pkg::heat_on_len(mode_res.tband)}),
    .period (crdc_pkg::heat_period_len(mode_res.tband)),
    .res    (heat_res)
  );

  always_comb begin
    wait_nxt = hepa_res.wait_secs;
    if (humid_res.wait_secs < wait_nxt) begin
      wait_nxt = humid_res.wait_secs;
    end
    if (heat_res.wait_secs < wait_nxt) begin
      wait_nxt = heat_res.wait_secs;
    end

    hepa_len_nxt = '0;
    if (override_r) begin
      hepa_cmd_nxt  = crdc_pkg::CMD_UNTOUCHED;
      humid_cmd_nxt = crdc_pkg::CMD_UNTOUCHED;
      fan_cmd_nxt   = crdc_pkg::CMD_UNTOUCHED;
      heat_cmd_nxt  = crdc_pkg::CMD_UNTOUCHED;
    end else begin
      hepa_cmd_nxt  = hepa_en ? hepa_res.cmd : crdc_pkg::CMD_OFF;
      humid_cmd_nxt = humid_en ? humid_res.cmd : crdc_pkg::CMD_OFF;
      heat_cmd_nxt  = heat_en ? heat_res.cmd : crdc_pkg::CMD_OFF;
      if (!humid_en) begin
        fan_cmd_nxt = crdc_pkg::CMD_OFF;
      end else if (humid_res.cmd == crdc_pkg::CMD_START) begin
        fan_cmd_nxt = crdc_pkg::CMD_START;
      end else begin
        fan_cmd_nxt = crdc_pkg::CMD_UNTOUCHED;
      end
      if (hepa_res.restart) begin
        hepa_len_nxt = hepa_on_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmode_r        <= crdc_pkg::TMODE_SAT;
      hmode_r        <= crdc_pkg::HMODE_SAT;
      heater_start_r <= '0;
      humid_start_r  <= '0;
      hepa_start_r   <= '0;
    end else if (s1_fire) begin
      tmode_r <= mode_res.tmode;
      hmode_r <= mode_res.hmode;
      if (hepa_res.restart) begin
        hepa_start_r <= s1_now_r;
      end
      if (humid_res.restart) begin
        humid_start_r <= s1_now_r;
      end
      if (heat_res.restart) begin
        heater_start_r <= s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      tmode_out_r <= mode_res.tmode;
      hmode_out_r <= mode_res.hmode;
      hepa_cmd_r  <= hepa_cmd_nxt;
      humid_cmd_r <= humid_cmd_nxt;
      fan_cmd_r   <= fan_cmd_nxt;
      heat_cmd_r  <= heat_cmd_nxt;
      humid_len_r <= crdc_pkg::hum_on_len(mode_res.hband);
      heat_len_r  <= crdc_pkg::heat_on_len(mode_res.tband);
      hepa_len_r  <= hepa_len_nxt;
      wait_r      <= wait_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_temp_mode             = tmode_out_r;
  assign out_hum_mode              = hmode_out_r;
  assign out_hepa_cmd              = hepa_cmd_r;
  assign out_humidifier_cmd        = humid_cmd_r;
  assign out_fan_cmd               = fan_cmd_r;
  assign out_heater_cmd            = heat_cmd_r;
  assign out_humidifier_pulse_secs = humid_len_r;
  assign out_heater_pulse_secs     = heat_len_r;
  assign out_hepa_pulse_secs       = hepa_len_r;
  assign out_wait_secs             = wait_r;

`ifndef SYNTHESIS
  a_wait_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> wait_r <= crdc_pkg::WAIT_MAX)
    else $error("wait above cap");

  a_override: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && override_r |-> wait_r == crdc_pkg::WAIT_MAX &&
      hepa_cmd_r == crdc_pkg::CMD_UNTOUCHED && heat_cmd_r == crdc_pkg::CMD_UNTOUCHED)
    else $error("override result touches relays");

  a_fan_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fan_cmd_r == crdc_pkg::CMD_START) ==
      (humid_cmd_r == crdc_pkg::CMD_START))
    else $error("fan start does not follow humidifier start");

  a_hepa_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hepa_len_r != '0 |-> hepa_cmd_r == crdc_pkg::CMD_START)
    else $error("hepa pulse without start");

  a_start_update: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && hepa_res.restart |=> hepa_start_r == $past(s1_now_r))
    else $error("hepa start not taken");
`endif

endmodule

`default_nettype wire

FILE: sv/crdc_mode.sv
// crdc_mode: hysteresis mode update and pulse band selection
// depends on crdc_pkg
`default_nettype none

module crdc_mode (
  input  wire logic signed [crdc_pkg::TEMP_W-1:0] temp,
  input  wire logic [crdc_pkg::HUM_W-1:0]         hum,
  input  wire logic signed [crdc_pkg::TEMP_W-1:0] on_temp,
  input  wire logic signed [crdc_pkg::TEMP_W-1:0] off_temp,
  input  wire logic signed [crdc_pkg::TEMP_W-1:0] high_temp,
  input  wire logic [crdc_pkg::HUM_W-1:0]         on_hum,
  input  wire logic [crdc_pkg::HUM_W-1:0]         off_hum,
  input  wire crdc_pkg::temp_mode_t               tmode_cur,
  input  wire crdc_pkg::hum_mode_t                hmode_cur,
  output crdc_pkg::mode_res_t                     res
);

  logic signed [crdc_pkg::TEMP_W:0] tdiff;
  logic signed [crdc_pkg::HUM_W:0]  hdiff;

  assign tdiff = {off_temp[crdc_pkg::TEMP_W-1], off_temp} - {temp[crdc_pkg::TEMP_W-1], temp};
  assign hdiff = $signed({1'b0, off_hum}) - $signed({1'b0, hum});

  always_comb begin
    res = '{tmode: tmode_cur, hmode: hmode_cur, tband: 3'd5, hband: 3'd5};

    if (temp < on_temp) begin
      res.tmode = crdc_pkg::TMODE_HEAT;
    end else if (temp >= off_temp && temp < high_temp) begin
      res.tmode = crdc_pkg::TMODE_SAT;
    end else if (temp >= high_temp) begin
      res.tmode = crdc_pkg::TMODE_OVER;
    end

    if (hum < on_hum) begin
      res.hmode = crdc_pkg::HMODE_HUMID;
    end else if (hum >= off_hum) begin
      res.hmode = crdc_pkg::HMODE_SAT;
    end

    if (tdiff <= 13'sd3) begin
      res.tband = 3'd1;
    end else if (tdiff <= 13'sd8) begin
      res.tband = 3'd2;
    end else if (tdiff <= 13'sd15) begin
      res.tband = 3'd3;
    end else if (tdiff <= 13'sd20) begin
      res.tband = 3'd4;
    end

    if (hdiff < 11'sd50) begin
      res.hband = 3'd1;
    end else if (hdiff < 11'sd100) begin
      res.hband = 3'd2;
    end else if (hdiff < 11'sd150) begin
      res.hband = 3'd3;
    end else if (hdiff < 11'sd200) begin
      res.hband = 3'd4;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crdc_timer.sv
// crdc_timer: on/period relay timer decision with wait capped at 60
// depends on crdc_pkg
`default_nettype none

module crdc_timer (
  input  wire logic                          enable,
  input  wire logic [crdc_pkg::TIME_W-1:0]   now,
  input  wire logic [crdc_pkg::TIME_W-1:0]   start,
  input  wire logic [crdc_pkg::SECS_W-1:0]   on_len,
  input  wire logic [crdc_pkg::SECS_W-1:0]   period,
  output crdc_pkg::timer_res_t               res
);

  logic [crdc_pkg::TIME_W-1:0] elapsed;
  logic                        in_period;
  logic                        in_on;
  logic [crdc_pkg::SECS_W-1:0] rem;

  assign elapsed   = now - start;
  assign in_period = elapsed < {{(crdc_pkg::TIME_W-crdc_pkg::SECS_W){1'b0}}, period};
  assign in_on     = elapsed < {{(crdc_pkg::TIME_W-crdc_pkg::SECS_W){1'b0}}, on_len};

  always_comb begin
    res.cmd     = crdc_pkg::CMD_OFF;
    res.restart = 1'b0;
    rem         = period;
    if (in_period && in_on) begin
      res.cmd = crdc_pkg::CMD_STAY_ON;
      rem     = on_len - elapsed[crdc_pkg::SECS_W-1:0];
    end else if (in_period) begin
      res.cmd = crdc_pkg::CMD_STAY_OFF;
      rem     = period - elapsed[crdc_pkg::SECS_W-1:0];
    end else begin
      res.cmd     = crdc_pkg::CMD_START;
      res.restart = enable;
    end

    if (!enable || rem >= {{(crdc_pkg::SECS_W-crdc_pkg::WAIT_W){1'b0}}, crdc_pkg::WAIT_MAX}) begin
      res.wait_secs = crdc_pkg::WAIT_MAX;
    end else begin
      res.wait_secs = rem[crdc_pkg::WAIT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/crdc_tb_pkg.sv
// crdc_tb_pkg: scoreboard for the climate relay duty controller with its own relay predictor
// depends on crdc_pkg for the command and mode enums, register indexes and field widths
package crdc_tb_pkg;
  import crdc_pkg::*;

  typedef struct packed {
    temp_mode_t          tmode;
    hum_mode_t           hmode;
    cmd_t                hepa_cmd;
    cmd_t                humidifier_cmd;
    cmd_t                fan_cmd;
    cmd_t                heater_cmd;
    logic [HUM_ON_W-1:0] hum_pulse;
    logic [HEAT_ON_W-1:0] heat_pulse;
    logic [SECS_W-1:0]   hepa_pulse;
    logic [WAIT_W-1:0]   wait_s;
  } relay_outcome_t;

  class relay_duty_scoreboard;
    logic signed [TEMP_W-1:0] on_temp, off_temp, high_temp;
    logic [HUM_W-1:0]         on_hum, off_hum;
    logic                     override_on;
    logic [SECS_W-1:0]        hepa_on, hepa_period;
    temp_mode_t               tmode_now;
    hum_mode_t                hmode_now;
    logic [TIME_W-1:0]        heater_start, humidifier_start, hepa_start;
    relay_outcome_t           pending_outcomes[$];
    int                       mismatches;

    function new();
      on_temp = 12'd100;
      off_temp = 12'd600;
      high_temp = 12'd800;
      on_hum = 10'd100;
      off_hum = 10'd400;
      override_on = 1'b0;
      hepa_on = '0;
      hepa_period = '0;
      tmode_now = TMODE_SAT;
      hmode_now = HMODE_SAT;
      heater_start = '0;
      humidifier_start = '0;
      hepa_start = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_ON_TEMP:     on_temp = data;
        REG_OFF_TEMP:    off_temp = data;
        REG_HIGH_TEMP:   high_temp = data;
        REG_ON_HUM:      on_hum = data[HUM_W-1:0];
        REG_OFF_HUM:     off_hum = data[HUM_W-1:0];
        REG_OVERRIDE:    override_on = data[0];
        REG_HEPA_ON:     hepa_on = data;
        REG_HEPA_PERIOD: hepa_period = data;
        default: ;
      endcase
    endfunction

    // on/period timer, folds its wait into the running minimum
    function cmd_t step_timer(inout logic [31:0] start, input logic [31:0] now,
                              input logic [31:0] on_len, input logic [31:0] period,
                              inout logic [31:0] wait_min);
      logic [31:0] elapsed, rem;
      cmd_t c;
      elapsed = now - start;
      if (elapsed < period) begin
        if (elapsed < on_len) begin
          c = CMD_STAY_ON;
          rem = on_len - elapsed;
        end else begin
          c = CMD_STAY_OFF;
          rem = period - elapsed;
        end
      end else begin
        c = CMD_START;
        start = now;
        rem = period;
      end
      if (rem < wait_min) wait_min = rem;
      return c;
    endfunction

    function relay_outcome_t predict_relays(logic [TIME_W-1:0] now,
                                            logic signed [TEMP_W-1:0] temp,
                                            logic [HUM_W-1:0] hum);
      relay_outcome_t r;
      int t, h, ton, toff, thigh, hon, hoff, tdiff, hdiff, tb, hb;
      logic [31:0] wait_min, heat_on, hum_on, hum_per;
      t = temp;
      h = hum;
      ton = on_temp;
      toff = off_temp;
      thigh = high_temp;
      hon = on_hum;
      hoff = off_hum;

      if (t < ton) tmode_now = TMODE_HEAT;
      else if (t >= toff && t < thigh) tmode_now = TMODE_SAT;
      else if (t >= thigh) tmode_now = TMODE_OVER;
      if (h < hon) hmode_now = HMODE_HUMID;
      else if (h >= hoff) hmode_now = HMODE_SAT;

      tdiff = toff - t;
      hdiff = hoff - h;
      if (tdiff <= 3) tb = 1;
      else if (tdiff <= 8) tb = 2;
      else if (tdiff <= 15) tb = 3;
      else if (tdiff <= 20) tb = 4;
      else tb = 5;
      if (hdiff < 50) hb = 1;
      else if (hdiff < 100) hb = 2;
      else if (hdiff < 150) hb = 3;
      else if (hdiff < 200) hb = 4;
      else hb = 5;
      heat_on = 20 + 10 * tb;
      hum_on = (hb == 5) ? 30 : 5 * hb;
      hum_per = 51 + 10 * hb;

      wait_min = 32'd60;
      r.hepa_cmd = CMD_UNTOUCHED;
      r.humidifier_cmd = CMD_UNTOUCHED;
      r.fan_cmd = CMD_UNTOUCHED;
      r.heater_cmd = CMD_UNTOUCHED;
      r.hepa_pulse = '0;
      if (!override_on) begin
        if (tmode_now == TMODE_OVER) begin
          r.hepa_cmd = step_timer(hepa_start, now, 32'(hepa_on), 32'(hepa_period), wait_min);
          if (r.hepa_cmd == CMD_START) r.hepa_pulse = hepa_on;
        end else begin
          r.hepa_cmd = CMD_OFF;
        end
        if (hmode_now == HMODE_HUMID) begin
          r.humidifier_cmd = step_timer(humidifier_start, now, hum_on, hum_per, wait_min);
          r.fan_cmd = (r.humidifier_cmd == CMD_START) ? CMD_START : CMD_UNTOUCHED;
        end else begin
          r.humidifier_cmd = CMD_OFF;
          r.fan_cmd = CMD_OFF;
        end
        if (tmode_now == TMODE_HEAT)
          r.heater_cmd = step_timer(heater_start, now, heat_on, 32'd500, wait_min);
        else
          r.heater_cmd = CMD_OFF;
      end
      r.tmode = tmode_now;
      r.hmode = hmode_now;
      r.hum_pulse = hum_on[HUM_ON_W-1:0];
      r.heat_pulse = heat_on[HEAT_ON_W-1:0];
      r.wait_s = wait_min[WAIT_W-1:0];
      return r;
    endfunction

    function void note_reading(logic [TIME_W-1:0] now, logic signed [TEMP_W-1:0] temp,
                               logic [HUM_W-1:0] hum);
      pending_outcomes.push_back(predict_relays(now, temp, hum));
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_outcome(relay_outcome_t act);
      relay_outcome_t e;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, got %h", $time, act);
        return;
      end
      e = pending_outcomes.pop_front();
      compare_field("temp_mode", e.tmode, act.tmode);
      compare_field("hum_mode", e.hmode, act.hmode);
      compare_field("hepa_cmd", e.hepa_cmd, act.hepa_cmd);
      compare_field("humidifier_cmd", e.humidifier_cmd, act.humidifier_cmd);
      compare_field("fan_cmd", e.fan_cmd, act.fan_cmd);
      compare_field("heater_cmd", e.heater_cmd, act.heater_cmd);
      compare_field("humidifier_pulse_secs", e.hum_pulse, act.hum_pulse);
      compare_field("heater_pulse_secs", e.heat_pulse, act.heat_pulse);
      compare_field("hepa_pulse_secs", e.hepa_pulse, act.hepa_pulse);
      compare_field("wait_secs", e.wait_s, act.wait_s);
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
// tb: drives sensor readings and register settings into climate_relay_duty_controller
// and checks every result against the scoreboard in crdc_tb_pkg; needs crdc_pkg and the rtl
module tb;
  import crdc_pkg::*;
  import crdc_tb_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 6;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 115;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [TIME_W-1:0]        in_now_secs;
  logic signed [TEMP_W-1:0] in_temp_tenths;
  logic [HUM_W-1:0]         in_hum_tenths;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_temp_mode;
  logic [1:0]               out_hum_mode;
  logic [2:0]               out_hepa_cmd;
  logic [2:0]               out_humidifier_cmd;
  logic [2:0]               out_fan_cmd;
  logic [2:0]               out_heater_cmd;
  logic [HUM_ON_W-1:0]      out_humidifier_pulse_secs;
  logic [HEAT_ON_W-1:0]     out_heater_pulse_secs;
  logic [SECS_W-1:0]        out_hepa_pulse_secs;
  logic [WAIT_W-1:0]        out_wait_secs;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_wdata;

  relay_duty_scoreboard sb;
  int idle_pct, stall_pct;
  int hold_requests, holds_done;
  int stuck_cycles;
  logic [TIME_W-1:0] clock_secs;

  climate_relay_duty_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_now_secs(in_now_secs),
    .in_temp_tenths(in_temp_tenths),
    .in_hum_tenths(in_hum_tenths),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_temp_mode(out_temp_mode),
    .out_hum_mode(out_hum_mode),
    .out_hepa_cmd(out_hepa_cmd),
    .out_humidifier_cmd(out_humidifier_cmd),
    .out_fan_cmd(out_fan_cmd),
    .out_heater_cmd(out_heater_cmd),
    .out_humidifier_pulse_secs(out_humidifier_pulse_secs),
    .out_heater_pulse_secs(out_heater_pulse_secs),
    .out_hepa_pulse_secs(out_hepa_pulse_secs),
    .out_wait_secs(out_wait_secs),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    relay_outcome_t act;
    if (rst_n && out_valid && out_ready) begin
      act.tmode = temp_mode_t'(out_temp_mode);
      act.hmode = hum_mode_t'(out_hum_mode);
      act.hepa_cmd = cmd_t'(out_hepa_cmd);
      act.humidifier_cmd = cmd_t'(out_humidifier_cmd);
      act.fan_cmd = cmd_t'(out_fan_cmd);
      act.heater_cmd = cmd_t'(out_heater_cmd);
      act.hum_pulse = out_humidifier_pulse_secs;
      act.heat_pulse = out_heater_pulse_secs;
      act.hepa_pulse = out_hepa_pulse_secs;
      act.wait_s = out_wait_secs;
      sb.check_outcome(act);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_reading(input logic [TIME_W-1:0] now, input logic [TEMP_W-1:0] temp,
                              input logic [HUM_W-1:0] hum);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_now_secs <= now;
    in_temp_tenths <= temp;
    in_hum_tenths <= hum;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_reading(now, temp, hum);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [11:0] on_t, input logic [11:0] off_t,
                               input logic [11:0] high_t, input logic [11:0] on_h,
                               input logic [11:0] off_h, input logic [11:0] ovr,
                               input logic [11:0] hepa_on, input logic [11:0] hepa_per);
    write_cfg(REG_ON_TEMP, on_t);
    write_cfg(REG_OFF_TEMP, off_t);
    write_cfg(REG_HIGH_TEMP, high_t);
    write_cfg(REG_ON_HUM, on_h);
    write_cfg(REG_OFF_HUM, off_h);
    write_cfg(REG_OVERRIDE, ovr);
    write_cfg(REG_HEPA_ON, hepa_on);
    write_cfg(REG_HEPA_PERIOD, hepa_per);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // temperatures cluster around the thresholds so every mode and band is hit
  function automatic logic [TEMP_W-1:0] pick_temp();
    int r, base;
    r = $urandom_range(99);
    if (r < 40) begin
      base = sb.off_temp;
      base = base - int'($urandom_range(30));
    end else if (r < 55) begin
      base = sb.on_temp;
      base = base + int'($urandom_range(6)) - 3;
    end else if (r < 70) begin
      base = sb.high_temp;
      base = base + int'($urandom_range(6)) - 3;
    end else if (r < 85) begin
      base = int'($urandom_range(1650)) - 400;
    end else begin
      base = int'($urandom);
    end
    return base[TEMP_W-1:0];
  endfunction

  function automatic logic [HUM_W-1:0] pick_hum();
    int r, base;
    r = $urandom_range(99);
    if (r < 40) begin
      base = sb.off_hum;
      base = base - int'($urandom_range(250));
    end else if (r < 65) begin
      base = sb.on_hum;
      base = base + int'($urandom_range(6)) - 3;
    end else if (r < 85) begin
      base = int'($urandom_range(1000));
    end else begin
      base = int'($urandom);
    end
    return base[HUM_W-1:0];
  endfunction

  // readings mostly a few seconds apart, sometimes long gaps or a jump anywhere
  function automatic logic [TIME_W-1:0] pick_now();
    int r;
    r = $urandom_range(99);
    if (r < 70) clock_secs = clock_secs + $urandom_range(12);
    else if (r < 90) clock_secs = clock_secs + $urandom_range(130, 13);
    else if (r < 97) clock_secs = clock_secs + $urandom_range(5000, 131);
    else clock_secs = $urandom;
    return clock_secs;
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_now_secs = '0;
    in_temp_tenths = '0;
    in_hum_tenths = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    clock_secs = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero hepa period, band edges, mode edges, timestamp wrap
    send_reading(32'd0, -12'sd2048, 10'd0);
    send_reading(32'd45, -12'sd2048, 10'd0);
    send_reading(32'd120, 12'sd2047, 10'd1023);
    send_reading(32'd121, 12'sd800, 10'd400);
    send_reading(32'd130, 12'sd799, 10'd399);
    send_reading(32'd131, 12'sd600, 10'd351);
    send_reading(32'd132, 12'sd597, 10'd350);
    send_reading(32'd133, 12'sd596, 10'd301);
    send_reading(32'd134, 12'sd592, 10'd300);
    send_reading(32'd135, 12'sd591, 10'd251);
    send_reading(32'd136, 12'sd585, 10'd250);
    send_reading(32'd137, 12'sd584, 10'd201);
    send_reading(32'd138, 12'sd580, 10'd200);
    send_reading(32'd139, 12'sd579, 10'd99);
    send_reading(32'd150, 12'sd99, 10'd100);
    send_reading(32'd600, 12'sd100, 10'd50);
    send_reading(32'hFFFF_FFFF, 12'sd99, 10'd50);
    send_reading(32'd3, 12'sd99, 10'd50);
    send_reading(32'h8000_0000, -12'sd400, 10'd1000);
    send_reading(32'h7FFF_FFFF, 12'sd1250, 10'd0);
    wait_drain();
    // override keeps relays untouched while modes move
    write_cfg(REG_OVERRIDE, 12'd1);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_reading(32'd200, 12'sd50, 10'd50);
    send_reading(32'd201, 12'sd900, 10'd900);
    send_reading(32'd202, 12'sd500, 10'd500);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      wait_drain();
      case (p)
        0: apply_setting(12'd100, 12'd600, 12'd800, 12'd100, 12'd400, 12'd0,
                         12'd10, 12'd40);
        1: apply_setting(12'd200, 12'd260, 12'd320, 12'd300, 12'd450, 12'd0,
                         12'd15, 12'd60);
        2: apply_setting(12'h7FF, 12'h800, 12'h800, 12'd1023, 12'd0, 12'd0,
                         12'd4095, 12'd4095);
        3: apply_setting(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        4: apply_setting(12'd150, 12'd400, 12'd700, 12'd200, 12'd500, 12'd1,
                         12'd20, 12'd50);
        5: apply_setting(-12'sd400, -12'sd100, 12'd1250, 12'd0, 12'd1000, 12'd0,
                         12'd3600, 12'd3600);
        6: apply_setting(12'd500, 12'd300, 12'd400, 12'd600, 12'd200, 12'd0,
                         12'd30, 12'd20);
        default: apply_setting(12'd100, 12'd600, 12'd800, 12'd100, 12'd400, 12'd0,
                               12'd5, 12'd120);
      endcase
      idle_pct = (p % 4 == 1) ? 58 : (p % 4 == 3) ? 30 : 0;
      stall_pct = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 30 : 0;
      // fill the pipeline against a blocked result side
      if (p == 0) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_reading(pick_now(), pick_temp(), pick_hum());
      end
    end

    wait_drain();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/crdc_pkg.sv
sv/crdc_mode.sv
sv/crdc_timer.sv
sv/climate_relay_duty_controller.sv
tb/sv/crdc_tb_pkg.sv
tb/sv/tb.sv
